@@ rtl/iiel_pkg.sv @@
// ----------------------------------------------------------------------------
// iiel_pkg: shared definitions of the indexed insert/erase list unit
// Sizes, command codes, state and cell operation types, and the data
// conversion functions used by the cell chain and its controller.
// ----------------------------------------------------------------------------
package iiel_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 6;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int STEP_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W     = CNT_W + 2;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP_FWD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP_REV = 2'd3;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_REV
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PREV,
        CELL_NEXT,
        CELL_LOAD
    } t_cell_op;

    function automatic t_data to_data(input logic [VAL_W-1:0] v);
        t_data d;
        for (int j = 0; j < DATA_WIDTH; j++) begin
            d[j] = (j < VAL_W) ? v[j] : v[VAL_W-1];
        end
        return d;
    endfunction

    function automatic logic [VAL_W-1:0] to_elem(input t_data d);
        logic [VAL_W-1:0] e;
        for (int j = 0; j < VAL_W; j++) begin
            e[j] = (j < DATA_WIDTH) ? d[j] : d[DATA_WIDTH-1];
        end
        return e;
    endfunction

endpackage

@@ rtl/indexed_insert_erase_list_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit: ordered list with positional insert/erase
// A command beat is taken at a clock edge where start is high and busy is
// low. Insert places i_value at i_index and erase removes the entry at
// i_index; both update the cell chain when taken and give one result
// beat in the next cycle, with o_ok, the new o_count and o_last set.
// A dump rotates the whole chain of CAPACITY cells once around while busy
// stays high. A forward dump emits entries head to tail at the start of
// the rotation; a reverse dump emits them tail to head at its end. Each
// result beat is registered and is marked by o_strobe for one cycle; the
// receiver cannot stall. A dump of an empty list gives one beat with
// o_element_valid low.
// Synchronous reset empties the list and returns to idle; stored words are
// not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [iiel_pkg::CMD_W-1:0]    i_cmd,
    input  logic [iiel_pkg::IDX_W-1:0]    i_index,
    input  logic signed [iiel_pkg::VAL_W-1:0] i_value,
    output logic                          o_strobe,
    output logic                          o_ok,
    output logic [iiel_pkg::CNT_OUT_W-1:0] o_count,
    output logic signed [iiel_pkg::VAL_W-1:0] o_element,
    output logic                          o_element_valid,
    output logic                          o_last
);

    iiel_pkg::t_state r_state;
    iiel_pkg::t_state n_state;
    logic [iiel_pkg::STEP_W-1:0] r_step;
    logic [iiel_pkg::STEP_W-1:0] n_step;
    logic [iiel_pkg::CNT_W-1:0]  r_count;
    logic [iiel_pkg::CNT_W-1:0]  n_count;

    logic                          r_strobe;
    logic                          n_strobe;
    logic                          r_ok;
    logic                          n_ok;
    logic [iiel_pkg::CNT_OUT_W-1:0] r_out_count;
    logic [iiel_pkg::CNT_OUT_W-1:0] n_out_count;
    logic [iiel_pkg::VAL_W-1:0]    r_element;
    logic [iiel_pkg::VAL_W-1:0]    n_element;
    logic                          r_valid;
    logic                          n_valid;
    logic                          r_last;
    logic                          n_last;

    iiel_pkg::t_data    w_data [iiel_pkg::CAPACITY];
    iiel_pkg::t_cell_op w_op   [iiel_pkg::CAPACITY];
    iiel_pkg::t_data    w_load;

    logic                         w_accept;
    logic                         w_ins_ok;
    logic                         w_er_ok;
    logic                         w_step_last;
    logic [iiel_pkg::SUM_W-1:0]   w_idx_ext;
    logic [iiel_pkg::SUM_W-1:0]   w_cnt_ext;
    logic [iiel_pkg::SUM_W-1:0]   w_step_ext;

    assign busy        = (r_state != iiel_pkg::S_IDLE);
    assign w_accept    = start && !busy;
    assign w_idx_ext   = iiel_pkg::SUM_W'(i_index);
    assign w_cnt_ext   = iiel_pkg::SUM_W'(r_count);
    assign w_step_ext  = iiel_pkg::SUM_W'(r_step);
    assign w_step_last = (r_step == iiel_pkg::STEP_W'(iiel_pkg::CAPACITY - 1));
    assign w_ins_ok    = (w_idx_ext <= w_cnt_ext)
                      && (w_cnt_ext < iiel_pkg::SUM_W'(iiel_pkg::CAPACITY));
    assign w_er_ok     = (w_idx_ext < w_cnt_ext);
    assign w_load      = iiel_pkg::to_data(i_value);

    always_comb begin
        for (int i = 0; i < iiel_pkg::CAPACITY; i++) begin
            w_op[i] = iiel_pkg::CELL_HOLD;
            if (r_state == iiel_pkg::S_FWD) begin
                w_op[i] = iiel_pkg::CELL_NEXT;
            end else if (r_state == iiel_pkg::S_REV) begin
                w_op[i] = iiel_pkg::CELL_PREV;
            end else if (w_accept && i_cmd == iiel_pkg::CMD_INSERT && w_ins_ok) begin
                if (iiel_pkg::SUM_W'(i) > w_idx_ext) begin
                    w_op[i] = iiel_pkg::CELL_PREV;
                end else if (iiel_pkg::SUM_W'(i) == w_idx_ext) begin
                    w_op[i] = iiel_pkg::CELL_LOAD;
                end
            end else if (w_accept && i_cmd == iiel_pkg::CMD_ERASE && w_er_ok) begin
                if (iiel_pkg::SUM_W'(i) >= w_idx_ext) begin
                    w_op[i] = iiel_pkg::CELL_NEXT;
                end
            end
        end
    end

    for (genvar g = 0; g < iiel_pkg::CAPACITY; g++) begin : g_cell
        iiel_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op[g]),
            .i_prev (w_data[(g + iiel_pkg::CAPACITY - 1) % iiel_pkg::CAPACITY]),
            .i_next (w_data[(g + 1) % iiel_pkg::CAPACITY]),
            .i_load (w_load),
            .o_data (w_data[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_count = r_count;
        case (r_state)
            iiel_pkg::S_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    case (i_cmd)
                        iiel_pkg::CMD_INSERT: begin
                            if (w_ins_ok) begin
                                n_count = r_count + iiel_pkg::CNT_W'(1);
                            end
                        end
                        iiel_pkg::CMD_ERASE: begin
                            if (w_er_ok) begin
                                n_count = r_count - iiel_pkg::CNT_W'(1);
                            end
                        end
                        iiel_pkg::CMD_DUMP_FWD: begin
                            if (r_count != '0) begin
                                n_state = iiel_pkg::S_FWD;
                            end
                        end
                        iiel_pkg::CMD_DUMP_REV: begin
                            if (r_count != '0) begin
                                n_state = iiel_pkg::S_REV;
                            end
                        end
                        default: n_state = iiel_pkg::S_IDLE;
                    endcase
                end
            end
            iiel_pkg::S_FWD, iiel_pkg::S_REV: begin
                n_step = r_step + iiel_pkg::STEP_W'(1);
                if (w_step_last) begin
                    n_state = iiel_pkg::S_IDLE;
                end
            end
            default: n_state = iiel_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_strobe    = 1'b0;
        n_ok        = 1'b1;
        n_out_count = iiel_pkg::CNT_OUT_W'(n_count);
        n_element   = '0;
        n_valid     = 1'b0;
        n_last      = 1'b1;
        case (r_state)
            iiel_pkg::S_IDLE: begin
                n_strobe = w_accept && (n_state == iiel_pkg::S_IDLE);
                if (i_cmd == iiel_pkg::CMD_INSERT) begin
                    n_ok = w_ins_ok;
                end else if (i_cmd == iiel_pkg::CMD_ERASE) begin
                    n_ok = w_er_ok;
                end
            end
            iiel_pkg::S_FWD: begin
                n_strobe  = (w_step_ext < w_cnt_ext);
                n_element = iiel_pkg::to_elem(w_data[0]);
                n_valid   = 1'b1;
                n_last    = ((w_step_ext + iiel_pkg::SUM_W'(1)) == w_cnt_ext);
            end
            iiel_pkg::S_REV: begin
                n_strobe  = ((w_step_ext + w_cnt_ext)
                            >= iiel_pkg::SUM_W'(iiel_pkg::CAPACITY));
                n_element = iiel_pkg::to_elem(w_data[iiel_pkg::CAPACITY-1]);
                n_valid   = 1'b1;
                n_last    = w_step_last;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iiel_pkg::S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok        <= n_ok;
        r_out_count <= n_out_count;
        r_element   <= n_element;
        r_valid     <= n_valid;
        r_last      <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_ok            = r_ok;
    assign o_count         = r_out_count;
    assign o_element       = r_element;
    assign o_element_valid = r_valid;
    assign o_last          = r_last;

    a_dump_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("Dump beats are not contiguous.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (iiel_pkg::SUM_W'(r_count) <= iiel_pkg::SUM_W'(iiel_pkg::CAPACITY)))
        else $error("Entry count exceeds capacity.");

    a_edit_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == iiel_pkg::CMD_INSERT || i_cmd == iiel_pkg::CMD_ERASE))
        |=> (o_strobe && o_last && !o_element_valid))
        else $error("Insert or erase did not give one final beat.");

    a_rev_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iiel_pkg::S_REV && w_step_last) |=> (o_strobe && o_last))
        else $error("Reverse dump did not end with a last beat.");

endmodule

@@ rtl/iiel_cell.sv @@
// ----------------------------------------------------------------------------
// iiel_cell: one storage cell of the list chain
// Holds one entry and each cycle keeps it, takes a neighbor's entry or
// loads the inserted word, as the controller directs.
// ----------------------------------------------------------------------------
module iiel_cell (
    input  logic               i_clk,
    input  iiel_pkg::t_cell_op i_op,
    input  iiel_pkg::t_data    i_prev,
    input  iiel_pkg::t_data    i_next,
    input  iiel_pkg::t_data    i_load,
    output iiel_pkg::t_data    o_data
);

    iiel_pkg::t_data r_data;
    iiel_pkg::t_data n_data;

    always_comb begin
        case (i_op)
            iiel_pkg::CELL_HOLD: n_data = r_data;
            iiel_pkg::CELL_PREV: n_data = i_prev;
            iiel_pkg::CELL_NEXT: n_data = i_next;
            iiel_pkg::CELL_LOAD: n_data = i_load;
            default:             n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ tb/indexed_insert_erase_list_unit_checker.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit_checker: predicts and checks list results
// Watches the command and result channels of the list unit. Each command
// beat taken by the unit updates a local copy of the list and queues the
// result beats it must cause. Each result beat is compared field by field
// with the oldest queued beat; every mismatch is counted, the first PRINT_LIMIT reported.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit_checker
    import iiel_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    o_strobe,
    input  logic                    o_ok,
    input  logic [CNT_OUT_W-1:0]    o_count,
    input  logic signed [VAL_W-1:0] o_element,
    input  logic                    o_element_valid,
    input  logic                    o_last,
    output int                      mismatch_count,
    output int                      pending_beats,
    output int                      checked_beats
);

    localparam int PRINT_LIMIT = 50;

    typedef logic [VAL_W-1:0] t_word;

    typedef struct {
        logic                 ok;
        logic [CNT_OUT_W-1:0] count;
        t_word                element;
        logic                 element_valid;
        logic                 last;
    } t_list_beat;

    t_data      cells [CAPACITY];
    int         held;
    t_list_beat expected_beats [$];

    initial begin
        mismatch_count = 0;
        pending_beats  = 0;
        checked_beats  = 0;
        held           = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s got %0h, expected %0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic push_beat(input logic ok, input t_word element,
                             input logic element_valid, input logic last);
        t_list_beat b;
        b.ok            = ok;
        b.count         = CNT_OUT_W'(held);
        b.element       = element;
        b.element_valid = element_valid;
        b.last          = last;
        expected_beats.push_back(b);
    endtask

    task automatic predict_command(input logic [CMD_W-1:0] cmd,
                                   input logic [IDX_W-1:0] idx, input t_word val);
        logic done_ok;
        int   pos;
        case (cmd)
            CMD_INSERT: begin
                done_ok = (idx <= held) && (held < CAPACITY);
                if (done_ok) begin
                    for (int k = held; k > idx; k--) begin
                        cells[k] = cells[k-1];
                    end
                    cells[idx] = t_data'($signed(val));
                    held++;
                end
                push_beat(done_ok, '0, 1'b0, 1'b1);
            end
            CMD_ERASE: begin
                done_ok = idx < held;
                if (done_ok) begin
                    for (int k = idx; k + 1 < held; k++) begin
                        cells[k] = cells[k+1];
                    end
                    held--;
                end
                push_beat(done_ok, '0, 1'b0, 1'b1);
            end
            CMD_DUMP_FWD, CMD_DUMP_REV: begin
                if (held == 0) begin
                    push_beat(1'b1, '0, 1'b0, 1'b1);
                end else begin
                    for (int k = 0; k < held; k++) begin
                        pos = (cmd == CMD_DUMP_FWD) ? k : held - 1 - k;
                        push_beat(1'b1, t_word'($signed(cells[pos])), 1'b1,
                                  k == held - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_beat();
        t_list_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch("result beat with nothing expected, element", o_element, '0);
            return;
        end
        want = expected_beats.pop_front();
        checked_beats++;
        if (o_ok !== want.ok) begin
            report_mismatch("ok", o_ok, want.ok);
        end
        if (o_count !== want.count) begin
            report_mismatch("count", o_count, want.count);
        end
        if (o_element !== want.element) begin
            report_mismatch("element", o_element, want.element);
        end
        if (o_element_valid !== want.element_valid) begin
            report_mismatch("element_valid", o_element_valid, want.element_valid);
        end
        if (o_last !== want.last) begin
            report_mismatch("last", o_last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            expected_beats.delete();
        end else begin
            if (o_strobe) begin
                check_beat();
            end
            if (start && !busy) begin
                predict_command(i_cmd, i_index, i_value);
            end
        end
        pending_beats = expected_beats.size();
    end

endmodule

@@ tb/indexed_insert_erase_list_unit_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit_tb: stimulus and verdict for the list unit
// Drives a short directed sequence over empty lists, boundary indexes and
// extreme words, then random command bursts that grow, mix and shrink the
// list through full and empty. A checker beside the unit predicts and
// compares every result beat; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit_tb;
    import iiel_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 310;
    localparam int BLOCK_ITEMS  = 52;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start   = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd   = CMD_INSERT;
    logic [IDX_W-1:0]        i_index = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_strobe;
    logic                    o_ok;
    logic [CNT_OUT_W-1:0]    o_count;
    logic signed [VAL_W-1:0] o_element;
    logic                    o_element_valid;
    logic                    o_last;

    int mismatch_count;
    int pending_beats;
    int checked_beats;
    int stall_cycles = 0;
    int burst_left   = 0;
    int list_len     = 0;
    int peak_len     = 0;
    int rejected     = 0;
    int cmd_total [4];

    indexed_insert_erase_list_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_index         (i_index),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_ok            (o_ok),
        .o_count         (o_count),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

    indexed_insert_erase_list_unit_checker list_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_index         (i_index),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_ok            (o_ok),
        .o_count         (o_count),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last          (o_last),
        .mismatch_count  (mismatch_count),
        .pending_beats   (pending_beats),
        .checked_beats   (checked_beats)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d result beats outstanding.",
                     stall_cycles, pending_beats);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return {1'b1, {(VAL_W-1){1'b0}}};
            1:       return {1'b0, {(VAL_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                         input logic signed [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                start   <= 1'b0;
                i_cmd   <= CMD_W'($urandom);
                i_index <= IDX_W'($urandom);
                i_value <= $urandom;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_index <= idx;
        i_value <= val;
        do begin
            @(posedge i_clk);
        end while (busy);
        cmd_total[cmd]++;
        case (cmd)
            CMD_INSERT: begin
                if (idx <= list_len && list_len < CAPACITY) begin
                    list_len++;
                end else begin
                    rejected++;
                end
            end
            CMD_ERASE: begin
                if (idx < list_len) begin
                    list_len--;
                end else begin
                    rejected++;
                end
            end
            default: ;
        endcase
        if (list_len > peak_len) begin
            peak_len = list_len;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_beats != 0) begin
            @(negedge i_clk);
        end
        burst_left = 0;
    endtask

    initial begin
        int                      roll;
        int                      ins_pct;
        int                      ers_pct;
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        idx;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_DUMP_FWD, '0, '0);
        issue(CMD_DUMP_REV, '1, '1);
        issue(CMD_ERASE, 6'd0, '0);
        issue(CMD_INSERT, 6'd1, 32'sh1234_5678);
        issue(CMD_INSERT, 6'd0, 32'sh7FFF_FFFF);
        issue(CMD_INSERT, 6'd0, 32'sh8000_0000);
        issue(CMD_INSERT, 6'd2, -32'sd1);
        issue(CMD_INSERT, 6'd1, '0);
        issue(CMD_INSERT, 6'd63, 32'sh5555_AAAA);
        issue(CMD_DUMP_FWD, 6'd21, '0);
        issue(CMD_DUMP_REV, 6'd42, '0);
        issue(CMD_ERASE, 6'd3, '0);
        issue(CMD_ERASE, 6'd63, '0);
        issue(CMD_ERASE, 6'd3, '0);
        issue(CMD_ERASE, 6'd0, '0);
        issue(CMD_DUMP_FWD, '0, '0);
        issue(CMD_DUMP_REV, '0, '0);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (n / BLOCK_ITEMS)
                0:       begin ins_pct = 80; ers_pct = 10; end
                3:       begin ins_pct = 90; ers_pct = 5;  end
                2, 5:    begin ins_pct = 15; ers_pct = 75; end
                default: begin ins_pct = 45; ers_pct = 45; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
                cmd = CMD_INSERT;
                idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                                  : IDX_W'($urandom_range(0, list_len));
            end else if (roll < ins_pct + ers_pct) begin
                cmd = CMD_ERASE;
                if ($urandom_range(0, 9) == 0 || list_len == 0) begin
                    idx = IDX_W'($urandom);
                end else begin
                    idx = IDX_W'($urandom_range(0, list_len - 1));
                end
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_DUMP_FWD : CMD_DUMP_REV;
                idx = IDX_W'($urandom);
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            issue(cmd, idx, rand_word());
        end

        wait_drained();
        repeat (CAPACITY + 4) @(negedge i_clk);

        $display("Sent %0d commands: %0d inserts, %0d erases, %0d dumps, %0d rejected.",
                 cmd_total[CMD_INSERT] + cmd_total[CMD_ERASE] + cmd_total[CMD_DUMP_FWD]
                 + cmd_total[CMD_DUMP_REV], cmd_total[CMD_INSERT], cmd_total[CMD_ERASE],
                 cmd_total[CMD_DUMP_FWD] + cmd_total[CMD_DUMP_REV], rejected);
        $display("Checked %0d result beats; the list peaked at %0d of %0d entries.",
                 checked_beats, peak_len, CAPACITY);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
